>>> hdl/wpsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpsc_pkg
// Shared types and constants of the waveform peak and shape classifier.
// ----------------------------------------------------------------------------
package wpsc_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int SUM_BITS       = 13;
   localparam int THR_BITS       = 15;
   localparam int MULT_BITS      = 6;
   localparam int COUNT_BITS     = 9;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int WIN_START      = 10;

   localparam logic [MULT_BITS-1:0] MULT_RESET = 6'd10;

   // Register index as it sits in the word address.
   localparam logic REG_MULTIPLIER = 1'b0;

   typedef enum logic [1:0] {
      WAVE_UNKNOWN  = 2'd0,
      WAVE_SINE     = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_class_type;

   typedef struct packed {
      logic accept;
      logic load_sums;
      logic scan_en;
      logic load_result;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctrl_status_type;

endpackage : wpsc_pkg
`default_nettype wire

>>> hdl/wpsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpsc_ctrl
// Sequencer: collects a block of samples, then runs the sum, window scan and
// result steps and owns both handshakes.
// ----------------------------------------------------------------------------
module wpsc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_last_sample,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output wpsc_pkg::ctrl_cmd_type        cmd,
   input  wire wpsc_pkg::ctrl_status_type status
);
   import wpsc_pkg::*;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_SUMS,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign req_ready = (state_ff == ST_COLLECT);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.accept      = (state_ff == ST_COLLECT) && req_valid;
      cmd.load_sums   = (state_ff == ST_SUMS);
      cmd.scan_en     = (state_ff == ST_SCAN);
      cmd.load_result = (state_ff == ST_RESULT) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_COLLECT: begin
               if (req_valid && req_last_sample) begin
                  state_ff <= ST_SUMS;
               end
            end
            ST_SUMS: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (slot_free) begin
                  state_ff <= ST_COLLECT;
               end
            end
            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase
      end
   end

endmodule : wpsc_ctrl
`default_nettype wire

>>> hdl/wpsc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpsc_datapath
// Sorted extreme registers, sample window memory, threshold counter and the
// result registers.
// ----------------------------------------------------------------------------
module wpsc_datapath #(
   parameter int BLOCK_LEN    = 1024,
   parameter int WINDOW_STORE = 512,
   parameter int TOP_K        = 5
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic [wpsc_pkg::SAMPLE_BITS-1:0]       req_sample,
   input  wire logic [wpsc_pkg::MULT_BITS-1:0]         multiplier,
   input  wire wpsc_pkg::ctrl_cmd_type                 cmd,
   output wpsc_pkg::ctrl_status_type                   status,
   output logic [wpsc_pkg::SUM_BITS-1:0]               rsp_max_pair_sum,
   output logic [wpsc_pkg::SUM_BITS-1:0]               rsp_min_pair_sum,
   output logic [wpsc_pkg::SUM_BITS-1:0]               rsp_peak_to_peak_half_codes,
   output logic [wpsc_pkg::COUNT_BITS-1:0]             rsp_above_count,
   output wpsc_pkg::wave_class_type                    rsp_wave_class
);
   import wpsc_pkg::*;

   localparam int PW    = $clog2(BLOCK_LEN + 1);
   localparam int AW    = $clog2(WINDOW_STORE);
   localparam int PTR_W = $clog2(WINDOW_STORE + 1);
   localparam int CW    = PTR_W;
   localparam int EW    = (PTR_W > 10) ? PTR_W : 10;
   localparam int GW    = (PW > EW) ? PW : EW;

   localparam logic [SUM_BITS-1:0] SMALL_EMPTY = SUM_BITS'(1 << SAMPLE_BITS);
   localparam logic [SUM_BITS-1:0] SAMPLE_MAX  = SUM_BITS'((1 << SAMPLE_BITS) - 1);

   logic signed [SUM_BITS-1:0] largest_ff  [TOP_K];
   logic signed [SUM_BITS-1:0] largest_in  [TOP_K];
   logic        [SUM_BITS-1:0] smallest_ff [TOP_K];
   logic        [SUM_BITS-1:0] smallest_in [TOP_K];

   logic [SAMPLE_BITS-1:0] window_mem [WINDOW_STORE];

   logic [PW-1:0]       position_ff;
   logic [PTR_W-1:0]    ptr_ff;
   logic [PTR_W-1:0]    end_ff;
   logic [PTR_W-1:0]    end_in;
   logic                rd_pending_ff;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [CW-1:0]       count_ff;
   logic [SUM_BITS-1:0] maxsum_ff;
   logic [SUM_BITS-1:0] minsum_ff;
   logic [SUM_BITS-1:0] maxsum_in;
   logic [SUM_BITS-1:0] minsum_in;
   logic [THR_BITS-1:0] thr_ff;
   logic                issue;
   logic [EW-1:0]       count_ext;
   wave_class_type      class_in;

   logic [SUM_BITS-1:0] max_pair_ff;
   logic [SUM_BITS-1:0] min_pair_ff;
   logic [SUM_BITS-1:0] p2p_ff;
   logic [COUNT_BITS-1:0] above_ff;
   wave_class_type      class_ff;

   // Insertion into the sorted lists. The compare results are monotone over
   // the slots, so a slot takes the new sample at the first hit and its
   // upper neighbor below it.
   always_comb begin
      logic signed [SUM_BITS-1:0] v_signed;
      logic [SUM_BITS-1:0]        v_unsigned;
      logic                       gt [TOP_K];
      logic                       lt [TOP_K];
      v_signed   = $signed({1'b0, req_sample});
      v_unsigned = {1'b0, req_sample};
      for (int j = 0; j < TOP_K; j++) begin
         gt[j] = v_signed > largest_ff[j];
         lt[j] = v_unsigned < smallest_ff[j];
      end
      for (int j = 0; j < TOP_K; j++) begin
         if (!gt[j]) begin
            largest_in[j] = largest_ff[j];
         end else if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
            largest_in[j] = largest_ff[(j > 0) ? j - 1 : 0];
         end else begin
            largest_in[j] = v_signed;
         end
         if (!lt[j]) begin
            smallest_in[j] = smallest_ff[j];
         end else if (j > 0 && lt[(j > 0) ? j - 1 : 0]) begin
            smallest_in[j] = smallest_ff[(j > 0) ? j - 1 : 0];
         end else begin
            smallest_in[j] = v_unsigned;
         end
      end
   end

   // Empty slots count as zero on the high side and full scale on the low side.
   always_comb begin
      logic [SUM_BITS-1:0] l0;
      logic [SUM_BITS-1:0] lk;
      logic [SUM_BITS-1:0] s0;
      logic [SUM_BITS-1:0] sk;
      l0 = largest_ff[0][SUM_BITS-1] ? '0 : largest_ff[0];
      lk = largest_ff[TOP_K-1][SUM_BITS-1] ? '0 : largest_ff[TOP_K-1];
      s0 = (smallest_ff[0] > SAMPLE_MAX) ? SAMPLE_MAX : smallest_ff[0];
      sk = (smallest_ff[TOP_K-1] > SAMPLE_MAX) ? SAMPLE_MAX : smallest_ff[TOP_K-1];
      maxsum_in = l0 + lk;
      minsum_in = s0 + sk;
   end

   always_comb begin
      logic [GW-1:0] stored;
      logic [GW-1:0] win_end;
      stored  = (GW'(position_ff) < GW'(WINDOW_STORE)) ? GW'(position_ff)
                                                        : GW'(WINDOW_STORE);
      win_end = GW'(EW'(multiplier) * EW'(12) + EW'(WIN_START));
      end_in  = (win_end > stored) ? PTR_W'(stored) : PTR_W'(win_end);
   end

   assign issue            = cmd.scan_en && (ptr_ff < end_ff);
   assign status.scan_done = !(ptr_ff < end_ff) && !rd_pending_ff;

   assign count_ext = EW'(count_ff);
   always_comb begin
      logic [EW-1:0] m;
      m = EW'(multiplier);
      if (count_ext < m * EW'(3) + EW'(5)) begin
         class_in = WAVE_TRIANGLE;
      end else if (count_ext < m * EW'(4) + EW'(5)) begin
         class_in = WAVE_SINE;
      end else if (count_ext < m * EW'(6) + EW'(25)) begin
         class_in = WAVE_SQUARE;
      end else begin
         class_in = WAVE_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TOP_K; j++) begin
            largest_ff[j]  <= '1;
            smallest_ff[j] <= SMALL_EMPTY;
         end
         position_ff   <= '0;
         ptr_ff        <= PTR_W'(WIN_START);
         end_ff        <= '0;
         rd_pending_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (cmd.accept) begin
            for (int j = 0; j < TOP_K; j++) begin
               largest_ff[j]  <= largest_in[j];
               smallest_ff[j] <= smallest_in[j];
            end
            if (GW'(position_ff) < GW'(BLOCK_LEN)) begin
               position_ff <= position_ff + PW'(1);
            end
         end else if (cmd.load_sums) begin
            for (int j = 0; j < TOP_K; j++) begin
               largest_ff[j]  <= '1;
               smallest_ff[j] <= SMALL_EMPTY;
            end
            position_ff <= '0;
         end
         if (cmd.load_sums) begin
            ptr_ff   <= PTR_W'(WIN_START);
            end_ff   <= end_in;
            count_ff <= '0;
         end else begin
            if (issue) begin
               ptr_ff <= ptr_ff + PTR_W'(1);
            end
            if (rd_pending_ff && ({rd_data_ff, 3'b000} > thr_ff)) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         rd_pending_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (GW'(position_ff) < GW'(WINDOW_STORE))) begin
         window_mem[AW'(position_ff)] <= req_sample;
      end
      if (issue) begin
         rd_data_ff <= window_mem[AW'(ptr_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sums) begin
         maxsum_ff <= maxsum_in;
         minsum_ff <= minsum_in;
         thr_ff    <= THR_BITS'(maxsum_in) * THR_BITS'(3) + THR_BITS'(minsum_in);
      end
      if (cmd.load_result) begin
         max_pair_ff <= maxsum_ff;
         min_pair_ff <= minsum_ff;
         p2p_ff      <= (maxsum_ff > minsum_ff) ? maxsum_ff - minsum_ff : '0;
         above_ff    <= COUNT_BITS'(count_ff);
         class_ff    <= class_in;
      end
   end

   assign rsp_max_pair_sum            = max_pair_ff;
   assign rsp_min_pair_sum            = min_pair_ff;
   assign rsp_peak_to_peak_half_codes = p2p_ff;
   assign rsp_above_count             = above_ff;
   assign rsp_wave_class              = class_ff;

endmodule : wpsc_datapath
`default_nettype wire

>>> hdl/waveform_peak_and_shape_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_peak_and_shape_classifier
// Ranks a block of ADC samples, counts window samples above the three-quarter
// level and classifies the wave shape.
// ----------------------------------------------------------------------------
// Samples enter on the req_ channel, one transaction each, with
// req_last_sample marking the end of a block; while the block collects, one
// sample is taken every cycle. After the last sample the block forms the pair
// sums, issues one memory read per window sample (min(12*multiplier+10, stored
// samples) - 10 reads, none if negative), compares the last read, sees the
// scan done and loads the result, which waits while the output register is
// still full. The next block's first sample is taken only after the result is
// loaded, and the scan goes through the single read port of the sample memory.
// One rsp_ transaction per block sits in an output register, so a stalled
// receiver holds only the next block's result step while its samples still
// stream in. The user must write the multiplier register over the APB port
// (addresses 0 to 3) only while the block is idle; the block does not enforce
// this. Reset empties the rank registers and the block position, clears
// rsp_valid and sets multiplier to 10.
// ----------------------------------------------------------------------------
module waveform_peak_and_shape_classifier #(
   parameter int BLOCK_LEN    = 1024,
   parameter int WINDOW_STORE = 512,
   parameter int TOP_K        = 5
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [wpsc_pkg::SAMPLE_BITS-1:0]      req_sample,
   input  wire logic                                  req_last_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [wpsc_pkg::SUM_BITS-1:0]              rsp_max_pair_sum,
   output logic [wpsc_pkg::SUM_BITS-1:0]              rsp_min_pair_sum,
   output logic [wpsc_pkg::SUM_BITS-1:0]              rsp_peak_to_peak_half_codes,
   output logic [wpsc_pkg::COUNT_BITS-1:0]            rsp_above_count,
   output logic [1:0]                                 rsp_wave_class,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [wpsc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [wpsc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [wpsc_pkg::CSR_DATA_BITS-1:0]         prdata,
   output logic                                       pready
);
   import wpsc_pkg::*;

   logic [MULT_BITS-1:0] multiplier_ff;
   logic                 reg_hit;
   ctrl_cmd_type         cmd;
   ctrl_status_type      status;
   wave_class_type       wave_class;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_MULTIPLIER);
   assign prdata  = reg_hit ? CSR_DATA_BITS'(multiplier_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= MULT_RESET;
      end else if (psel && penable && pwrite && reg_hit) begin
         multiplier_ff <= pwdata[MULT_BITS-1:0];
      end
   end

   wpsc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .status          (status)
   );

   wpsc_datapath #(
      .BLOCK_LEN    (BLOCK_LEN),
      .WINDOW_STORE (WINDOW_STORE),
      .TOP_K        (TOP_K)
   ) u_datapath (
      .clock                       (clock),
      .reset                       (reset),
      .req_sample                  (req_sample),
      .multiplier                  (multiplier_ff),
      .cmd                         (cmd),
      .status                      (status),
      .rsp_max_pair_sum            (rsp_max_pair_sum),
      .rsp_min_pair_sum            (rsp_min_pair_sum),
      .rsp_peak_to_peak_half_codes (rsp_peak_to_peak_half_codes),
      .rsp_above_count             (rsp_above_count),
      .rsp_wave_class              (wave_class)
   );

   assign rsp_wave_class = wave_class;

endmodule : waveform_peak_and_shape_classifier
`default_nettype wire

>>> verif/waveform_peak_and_shape_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waveform_peak_and_shape_classifier_tb
// Streams sample blocks of several wave shapes and lengths into the classifier
// under random sender gaps and receiver stalls. The multiplier is changed
// between idle phases. A scoreboard predicts each block's pair sums, window
// count and class and checks every result transaction in order.
// ----------------------------------------------------------------------------
module waveform_peak_and_shape_classifier_tb;
   import wpsc_pkg::*;

   localparam int BLOCK_LEN     = 1024;
   localparam int WINDOW_STORE  = 512;
   localparam int TOP_K         = 5;
   localparam int MAX_CODE      = (1 << SAMPLE_BITS) - 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 600;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int MIN_BLOCKS    = 24;

   localparam logic [CSR_ADDR_BITS-1:0] MULT_ADDR = {REG_MULTIPLIER, 2'b00};

   typedef enum int {SHAPE_PULSE, SHAPE_RAMP, SHAPE_NOISE, SHAPE_FLAT} shape_kind_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]   max_sum;
      logic [SUM_BITS-1:0]   min_sum;
      logic [SUM_BITS-1:0]   p2p;
      logic [COUNT_BITS-1:0] count;
      wave_class_type        cls;
   } shape_result_type;

   // Tracks the rank registers and stored window of the block in flight and
   // queues the result each finished block must produce.
   class peak_shape_scoreboard;
      logic signed [SUM_BITS-1:0] hi_rank [TOP_K];
      logic [SUM_BITS-1:0]        lo_rank [TOP_K];
      logic [SAMPLE_BITS-1:0]     stored_samples [WINDOW_STORE];
      int                         block_pos;
      logic [MULT_BITS-1:0]       multiplier;
      shape_result_type           expected_shapes [$];
      int                         errors;

      function new();
         multiplier = MULT_RESET;
         errors = 0;
         clear_block();
      endfunction

      function void clear_block();
         for (int k = 0; k < TOP_K; k++) begin
            hi_rank[k] = -1;
            lo_rank[k] = SUM_BITS'(MAX_CODE + 1);
         end
         block_pos = 0;
      endfunction

      function void set_multiplier(input logic [MULT_BITS-1:0] value);
         multiplier = value;
      endfunction

      function int pending();
         return expected_shapes.size();
      endfunction

      function void note_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
         logic signed [SUM_BITS-1:0] v;
         shape_result_type r;
         bit placed;
         int hi_a, hi_b, lo_a, lo_b, top_sum, bottom_sum, p2p, thr;
         int stored, stop, cnt, m;
         v = $signed({1'b0, s});
         placed = 0;
         for (int j = 0; j < TOP_K; j++) begin
            if (!placed && v > hi_rank[j]) begin
               for (int k = TOP_K - 1; k > j; k--) hi_rank[k] = hi_rank[k-1];
               hi_rank[j] = v;
               placed = 1;
            end
         end
         placed = 0;
         for (int j = 0; j < TOP_K; j++) begin
            if (!placed && {1'b0, s} < lo_rank[j]) begin
               for (int k = TOP_K - 1; k > j; k--) lo_rank[k] = lo_rank[k-1];
               lo_rank[j] = {1'b0, s};
               placed = 1;
            end
         end
         if (block_pos < WINDOW_STORE) stored_samples[block_pos] = s;
         if (block_pos < BLOCK_LEN) block_pos++;
         if (!last) return;

         // Empty rank slots of a short block count as the far end of the range.
         hi_a = (hi_rank[0] < 0) ? 0 : hi_rank[0];
         hi_b = (hi_rank[TOP_K-1] < 0) ? 0 : hi_rank[TOP_K-1];
         lo_a = (lo_rank[0] > MAX_CODE) ? MAX_CODE : lo_rank[0];
         lo_b = (lo_rank[TOP_K-1] > MAX_CODE) ? MAX_CODE : lo_rank[TOP_K-1];
         top_sum = hi_a + hi_b;
         bottom_sum = lo_a + lo_b;
         p2p = (top_sum > bottom_sum) ? top_sum - bottom_sum : 0;
         thr = 3 * top_sum + bottom_sum;

         m = multiplier;
         stored = (block_pos < WINDOW_STORE) ? block_pos : WINDOW_STORE;
         stop = 12 * m + WIN_START;
         if (stop > stored) stop = stored;
         cnt = 0;
         for (int t = WIN_START; t < stop; t++) begin
            if (8 * int'(stored_samples[t]) > thr) cnt++;
         end

         if (cnt < 3 * m + 5) r.cls = WAVE_TRIANGLE;
         else if (cnt < 4 * m + 5) r.cls = WAVE_SINE;
         else if (cnt < 6 * m + 25) r.cls = WAVE_SQUARE;
         else r.cls = WAVE_UNKNOWN;
         r.max_sum = SUM_BITS'(top_sum);
         r.min_sum = SUM_BITS'(bottom_sum);
         r.p2p     = SUM_BITS'(p2p);
         r.count   = COUNT_BITS'(cnt);
         expected_shapes.push_back(r);
         clear_block();
      endfunction

      function void compare(input string field, input logic [15:0] want,
                            input logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(input shape_result_type got);
         shape_result_type want;
         if (expected_shapes.size() == 0) begin
            $display("%0t: result with no block outstanding, expected none, %s %0d %0d %0d %0d %0d",
                     $time, "actual", got.max_sum, got.min_sum, got.p2p, got.count,
                     got.cls);
            errors++;
            return;
         end
         want = expected_shapes.pop_front();
         compare("max_pair_sum", want.max_sum, got.max_sum);
         compare("min_pair_sum", want.min_sum, got.min_sum);
         compare("peak_to_peak_half_codes", want.p2p, got.p2p);
         compare("above_count", want.count, got.count);
         compare("wave_class", want.cls, got.cls);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [SAMPLE_BITS-1:0]     req_sample;
   logic                       req_last_sample;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [SUM_BITS-1:0]        rsp_max_pair_sum;
   logic [SUM_BITS-1:0]        rsp_min_pair_sum;
   logic [SUM_BITS-1:0]        rsp_peak_to_peak_half_codes;
   logic [COUNT_BITS-1:0]      rsp_above_count;
   logic [1:0]                 rsp_wave_class;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_BITS-1:0]   paddr;
   logic [CSR_DATA_BITS-1:0]   pwdata;
   logic [CSR_DATA_BITS-1:0]   prdata;
   logic                       pready;

   peak_shape_scoreboard shapes;
   int burst_left;
   int items_sent;
   int blocks_sent;
   int ready_run;
   int stall_run;
   int mult_now;

   waveform_peak_and_shape_classifier #(
      .BLOCK_LEN    (BLOCK_LEN),
      .WINDOW_STORE (WINDOW_STORE),
      .TOP_K        (TOP_K)
   ) DUT (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_sample                  (req_sample),
      .req_last_sample             (req_last_sample),
      .rsp_valid                   (rsp_valid),
      .rsp_ready                   (rsp_ready),
      .rsp_max_pair_sum            (rsp_max_pair_sum),
      .rsp_min_pair_sum            (rsp_min_pair_sum),
      .rsp_peak_to_peak_half_codes (rsp_peak_to_peak_half_codes),
      .rsp_above_count             (rsp_above_count),
      .rsp_wave_class              (rsp_wave_class),
      .psel                        (psel),
      .penable                     (penable),
      .pwrite                      (pwrite),
      .paddr                       (paddr),
      .pwdata                      (pwdata),
      .prdata                      (prdata),
      .pready                      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Receiver: alternating runs of ready and stall cycles of random length.
   always @(posedge clock) begin
      if (ready_run > 0) begin
         ready_run--;
         rsp_ready <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
         rsp_ready <= 1'b0;
      end else begin
         ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(0, 20);
         stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      shape_result_type got;
      if (!reset) begin
         if (req_valid && req_ready) shapes.note_sample(req_sample, req_last_sample);
         if (rsp_valid && rsp_ready) begin
            got.max_sum = rsp_max_pair_sum;
            got.min_sum = rsp_min_pair_sum;
            got.p2p     = rsp_peak_to_peak_half_codes;
            got.count   = rsp_above_count;
            got.cls     = wave_class_type'(rsp_wave_class);
            shapes.check_result(got);
         end
      end
   end

   // Presents one sample and waits for its transaction; between bursts the
   // sender drops valid for a random pause.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (last) blocks_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_block(input int len, input shape_kind_type kind);
      int period, half, lo, hi, duty, pos, tri_pos, level;
      period = (mult_now == 0) ? 12 : 12 * mult_now;
      half = period / 2;
      lo = $urandom_range(0, MAX_CODE);
      hi = $urandom_range(0, MAX_CODE);
      duty = $urandom_range(0, period);
      for (int i = 0; i < len; i++) begin
         pos = i % period;
         case (kind)
            SHAPE_PULSE: level = (pos < duty) ? hi : lo;
            SHAPE_RAMP: begin
               tri_pos = (pos < half) ? pos : period - pos;
               level = lo + ((hi - lo) * tri_pos) / half;
            end
            SHAPE_NOISE: level = $urandom_range(0, MAX_CODE);
            default: level = lo;
         endcase
         level += $urandom_range(0, 3);
         if (level > MAX_CODE) level = MAX_CODE;
         send_sample(SAMPLE_BITS'(level), i == len - 1);
      end
   endtask

   // Waits until every block's result has been taken and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shapes.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_multiplier(input int m);
      logic [CSR_DATA_BITS-1:0] word;
      word = ($urandom_range(0, 1) == 1) ? CSR_DATA_BITS'($urandom) : '0;
      word[MULT_BITS-1:0] = MULT_BITS'(m);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MULT_ADDR;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      shapes.set_multiplier(word[MULT_BITS-1:0]);
      mult_now = word[MULT_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic run_phase(input int m, input int nblocks, input int len_lo,
                            input int len_hi);
      int len;
      write_multiplier(m);
      for (int b = 0; b < nblocks; b++) begin
         if (len_lo < len_hi && $urandom_range(0, 4) == 0) len = $urandom_range(1, 12);
         else len = $urandom_range(len_lo, len_hi);
         send_block(len, shape_kind_type'($urandom_range(0, 3)));
      end
      drain();
   endtask

   initial begin
      int m, len_hi;
      shapes = new();
      burst_left = 1;
      items_sent = 0;
      blocks_sent = 0;
      ready_run = 0;
      stall_run = 0;
      mult_now = MULT_RESET;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sample      <= '0;
      req_last_sample <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-sample blocks leave rank slots empty; the peak-to-peak goes
      // negative and saturates to zero on both.
      send_sample(SAMPLE_BITS'(MAX_CODE), 1'b1);
      send_sample('0, 1'b1);
      // Exactly ten samples: the window starts past the end and is empty.
      for (int i = 0; i < 10; i++)
         send_sample((i % 2 == 0) ? SAMPLE_BITS'(MAX_CODE) : '0, i == 9);
      // Eleven samples: one window sample, at full scale.
      for (int i = 0; i < 11; i++)
         send_sample((i % 3 == 0) ? '0 : SAMPLE_BITS'(MAX_CODE), i == 10);
      for (int i = 0; i < 5; i++)
         send_sample(SAMPLE_BITS'(i * 1000), i == 4);
      drain();

      // Extremes of the multiplier: full window, window clipped to the store,
      // and a zero-length window.
      run_phase(1, 6, 5, 40);
      run_phase(40, 1, 500, 500);
      run_phase(63, 1, 520, 520);
      run_phase(0, 4, 1, 30);

      while (items_sent < RANDOM_ITEMS || blocks_sent < MIN_BLOCKS) begin
         m = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
         len_hi = 12 * m + 30;
         if (len_hi > 200) len_hi = 200;
         run_phase(m, $urandom_range(3, 8), 5, len_hi);
      end

      repeat (END_CYCLES) @(posedge clock);
      if (shapes.errors == 0 && shapes.pending() == 0) begin
         $display("PASS");
      end else begin
         if (shapes.pending() != 0)
            $display("%0t: %0d results expected, 0 actual", $time, shapes.pending());
         $display("FAIL");
      end
      $finish;
   end

endmodule
